// File: hdl/nbc_pkg.sv
// Shared types and constants for the neighbour cache with entry ageing.
`default_nettype none

package nbc_pkg;

  localparam int unsigned Entries = 32;
  localparam int unsigned IdxW    = $clog2(Entries);
  localparam int unsigned SlotW   = 5;
  localparam int unsigned IpW     = 32;
  localparam int unsigned MacW    = 48;
  localparam int unsigned TimeW   = 48;

  localparam logic [TimeW-1:0] LifetimeReset = TimeW'(5 * 60 * 1000);

  localparam logic KindLookup = 1'b0;
  localparam logic KindInsert = 1'b1;

  typedef struct packed {
    logic             kind;
    logic [IpW-1:0]   ip;
    logic [MacW-1:0]  new_mac;
    logic [TimeW-1:0] now_ms;
  } req_t;

  typedef struct packed {
    logic             found;
    logic [MacW-1:0]  mac_out;
    logic [SlotW-1:0] slot;
  } res_t;

  typedef struct packed {
    logic [IpW-1:0]   ip;
    logic [MacW-1:0]  mac;
    logic [TimeW-1:0] stamp;
  } entry_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;
    logic step;
    logic commit;
  } cmd_t;

  // Status from the datapath for the entry under evaluation.
  typedef struct packed {
    logic hit;
    logic last;
  } stat_t;

endpackage

`default_nettype wire

// File: hdl/neighbor_cache_with_ttl.sv
// Top level of the neighbour cache: IPv4 to MAC table with entry ageing.
`default_nettype none

// A request is taken when start is high and busy is low. The block then reads
// the entry table one entry per clock through a single RAM read port and stops
// at the first valid entry whose address matches, or after the last entry.
// The result appears on res_o for exactly one clock with res_strobe_o high and
// cannot be held off; a new request may be started in that same clock. The
// lifetime register may be written at any time the block is idle; cfg_ready_o
// is always high.
module neighbor_cache_with_ttl (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire logic                      start,
  output logic                           busy,
  input  wire nbc_pkg::req_t             req_i,
  output nbc_pkg::res_t                  res_o,
  output logic                           res_strobe_o,
  input  wire logic                      cfg_valid_i,
  output logic                           cfg_ready_o,
  input  wire logic [nbc_pkg::TimeW-1:0] cfg_data_i
);

  nbc_pkg::cmd_t  cmd;
  nbc_pkg::stat_t stat;

  assign cfg_ready_o = 1'b1;

  nbc_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start  (start),
    .busy   (busy),
    .stat_i (stat),
    .cmd_o  (cmd)
  );

  nbc_datapath u_datapath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .stat_o       (stat),
    .req_i        (req_i),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_data_i   (cfg_data_i),
    .res_o        (res_o),
    .res_strobe_o (res_strobe_o)
  );

`ifndef SYNTHESIS
  // A result only ever follows a clock spent scanning.
  a_strobe_after_scan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_strobe_o |-> $past(busy))
    else $error("result strobe without a preceding scan cycle");

  // An accepted request always starts a scan.
  a_start_scans: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> busy)
    else $error("accepted request did not start a scan");

  // Only a live lookup hit carries a MAC address.
  a_mac_only_on_hit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_strobe_o && !res_o.found) |-> (res_o.mac_out == '0))
    else $error("non-zero MAC on a miss");

  // The scan finishes within one pass of the table.
  a_scan_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (busy && $past(busy) && (u_datapath.eval_q == '0)) |-> 1'b0)
    else $error("scan wrapped past the last entry");
`endif

endmodule

`default_nettype wire

// File: hdl/nbc_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
`default_nettype none

module nbc_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 32
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output logic      [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

// File: hdl/nbc_ctrl.sv
// Controller state machine that sequences the table scan of each request.
`default_nettype none

module nbc_ctrl (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          start,
  output logic               busy,
  input  wire nbc_pkg::stat_t stat_i,
  output nbc_pkg::cmd_t      cmd_o
);

  localparam logic [0:0] StIdle = 1'b0;
  localparam logic [0:0] StScan = 1'b1;

  logic [0:0] state_q, state_d;

  always_comb begin
    state_d     = state_q;
    cmd_o       = '0;
    unique case (state_q)
      StIdle: begin
        if (start) begin
          cmd_o.load = 1'b1;
          state_d    = StScan;
        end
      end
      StScan: begin
        cmd_o.step = 1'b1;
        // A matching entry ends the scan early; otherwise the last entry does.
        if (stat_i.hit || stat_i.last) begin
          cmd_o.commit = 1'b1;
          state_d      = StIdle;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
    end else begin
      state_q <= state_d;
    end
  end

  assign busy = (state_q == StScan);

endmodule

`default_nettype wire

// File: hdl/nbc_datapath.sv
// Datapath: entry storage, valid bits, scan trackers, lifetime and result register.
`default_nettype none

module nbc_datapath (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  input  wire nbc_pkg::cmd_t                      cmd_i,
  output nbc_pkg::stat_t                          stat_o,
  input  wire nbc_pkg::req_t                      req_i,
  input  wire logic                               cfg_valid_i,
  input  wire logic [nbc_pkg::TimeW-1:0]          cfg_data_i,
  output nbc_pkg::res_t                           res_o,
  output logic                                    res_strobe_o
);

  localparam logic [nbc_pkg::IdxW-1:0] LastIdx = nbc_pkg::IdxW'(nbc_pkg::Entries - 1);

  nbc_pkg::req_t                req_q;
  logic [nbc_pkg::TimeW-1:0]    life_q;
  logic [nbc_pkg::Entries-1:0]  valid_q;
  logic [nbc_pkg::IdxW-1:0]     eval_q;

  logic                         free_found_q, free_found_d;
  logic [nbc_pkg::IdxW-1:0]     free_idx_q, free_idx_d;
  logic                         old_found_q, old_found_d;
  logic [nbc_pkg::IdxW-1:0]     old_idx_q, old_idx_d;
  logic [nbc_pkg::TimeW-1:0]    old_stamp_q, old_stamp_d;

  nbc_pkg::res_t                res_q, res_d;
  logic                         strobe_q;

  logic [$bits(nbc_pkg::entry_t)-1:0] ram_rdata;
  nbc_pkg::entry_t              rd;
  nbc_pkg::entry_t              wr;
  logic                         ram_we, ram_re;
  logic [nbc_pkg::IdxW-1:0]     ram_waddr, ram_raddr;

  logic                         ent_valid;
  logic                         ip_hit;
  logic [nbc_pkg::TimeW-1:0]    age;
  logic                         expired;
  logic [nbc_pkg::IdxW-1:0]     target;
  logic [nbc_pkg::IdxW-1:0]     slot_idx;
  logic [nbc_pkg::IdxW+nbc_pkg::SlotW-1:0] slot_ext;

  nbc_ram #(
    .Width ($bits(nbc_pkg::entry_t)),
    .Depth (nbc_pkg::Entries)
  ) u_entry_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (wr),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  always_comb begin
    rd        = nbc_pkg::entry_t'(ram_rdata);
    ent_valid = valid_q[eval_q];
    ip_hit    = ent_valid && (rd.ip == req_q.ip);
    age       = req_q.now_ms - rd.stamp;
    expired   = age > life_q;

    stat_o.hit  = ip_hit;
    stat_o.last = (eval_q == LastIdx);

    // Running choice of the first free entry and the oldest valid entry.
    free_found_d = free_found_q;
    free_idx_d   = free_idx_q;
    if (!free_found_q && !ent_valid) begin
      free_found_d = 1'b1;
      free_idx_d   = eval_q;
    end
    old_found_d = old_found_q;
    old_idx_d   = old_idx_q;
    old_stamp_d = old_stamp_q;
    if (ent_valid && (!old_found_q || (rd.stamp < old_stamp_q))) begin
      old_found_d = 1'b1;
      old_idx_d   = eval_q;
      old_stamp_d = rd.stamp;
    end

    if (free_found_d) begin
      target = free_idx_d;
    end else if (old_found_d) begin
      target = old_idx_d;
    end else begin
      target = '0;
    end

    ram_re    = cmd_i.load || cmd_i.step;
    ram_raddr = cmd_i.load ? '0 : eval_q + nbc_pkg::IdxW'(1);
    ram_we    = cmd_i.commit && (req_q.kind == nbc_pkg::KindInsert);
    ram_waddr = ip_hit ? eval_q : target;
    wr.ip     = req_q.ip;
    wr.mac    = req_q.new_mac;
    wr.stamp  = req_q.now_ms;

    res_d = '0;
    if (req_q.kind == nbc_pkg::KindLookup) begin
      slot_idx = ip_hit ? eval_q : '0;
      if (ip_hit && !expired) begin
        res_d.found   = 1'b1;
        res_d.mac_out = rd.mac;
      end
    end else begin
      slot_idx    = ram_waddr;
      res_d.found = ip_hit;
    end
    slot_ext   = {{nbc_pkg::SlotW{1'b0}}, slot_idx};
    res_d.slot = slot_ext[nbc_pkg::SlotW-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      life_q   <= nbc_pkg::LifetimeReset;
      valid_q  <= '0;
      strobe_q <= 1'b0;
    end else begin
      if (cfg_valid_i) begin
        life_q <= cfg_data_i;
      end
      strobe_q <= cmd_i.commit;
      if (cmd_i.commit) begin
        if (req_q.kind == nbc_pkg::KindInsert) begin
          valid_q[ram_waddr] <= 1'b1;
        end else if (ip_hit && expired) begin
          valid_q[eval_q] <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      eval_q       <= '0;
      free_found_q <= 1'b0;
      old_found_q  <= 1'b0;
    end else if (cmd_i.load) begin
      eval_q       <= '0;
      free_found_q <= 1'b0;
      old_found_q  <= 1'b0;
    end else if (cmd_i.step && !cmd_i.commit) begin
      eval_q       <= eval_q + nbc_pkg::IdxW'(1);
      free_found_q <= free_found_d;
      old_found_q  <= old_found_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      req_q <= req_i;
    end
    if (cmd_i.step && !cmd_i.commit) begin
      free_idx_q  <= free_idx_d;
      old_idx_q   <= old_idx_d;
      old_stamp_q <= old_stamp_d;
    end
    if (cmd_i.commit) begin
      res_q <= res_d;
    end
  end

  assign res_o        = res_q;
  assign res_strobe_o = strobe_q;

endmodule

`default_nettype wire

// File: tb/sv/tb_neighbor_cache_with_ttl.sv
// Self-checking testbench for the neighbour cache with entry ageing.
`timescale 1ns / 1ps

module tb_neighbor_cache_with_ttl;

  localparam int unsigned PoolSize    = 40;
  localparam int unsigned CycleLimit  = 500000;
  localparam int unsigned ReportLimit = 10;

  typedef struct packed {
    nbc_pkg::req_t rq;
    logic [4:0]    gap;
  } queued_req_t;

  logic                      clk_i       = 1'b0;
  logic                      rst_ni      = 1'b0;
  logic                      start       = 1'b0;
  logic                      busy;
  nbc_pkg::req_t             req_i       = '0;
  nbc_pkg::res_t             res_o;
  logic                      res_strobe_o;
  logic                      cfg_valid_i = 1'b0;
  logic                      cfg_ready_o;
  logic [nbc_pkg::TimeW-1:0] cfg_data_i  = '0;

  neighbor_cache_with_ttl u_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start        (start),
    .busy         (busy),
    .req_i        (req_i),
    .res_o        (res_o),
    .res_strobe_o (res_strobe_o),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_o  (cfg_ready_o),
    .cfg_data_i   (cfg_data_i)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Shadow copy of the table and the lifetime register.
  logic                      shadow_valid [nbc_pkg::Entries];
  logic [nbc_pkg::IpW-1:0]   shadow_ip    [nbc_pkg::Entries];
  logic [nbc_pkg::MacW-1:0]  shadow_mac   [nbc_pkg::Entries];
  logic [nbc_pkg::TimeW-1:0] shadow_stamp [nbc_pkg::Entries];
  logic [nbc_pkg::TimeW-1:0] lifetime_ms = nbc_pkg::LifetimeReset;

  queued_req_t               req_backlog[$];
  nbc_pkg::res_t             awaited_res[$];
  int unsigned               n_queued, n_taken, fault_count, cycle_count;
  int unsigned               n_hit, n_miss, n_expired, n_refresh, n_fill, n_evict;
  logic [nbc_pkg::IpW-1:0]   ip_pool [PoolSize];
  logic [nbc_pkg::TimeW-1:0] clock_ms;

  initial begin
    for (int i = 0; i < nbc_pkg::Entries; i++) begin
      shadow_valid[i] = 1'b0;
      shadow_ip[i]    = '0;
      shadow_mac[i]   = '0;
      shadow_stamp[i] = '0;
    end
  end

  // Applies one request to the shadow table and returns the result it causes.
  function automatic nbc_pkg::res_t cache_predict(input nbc_pkg::req_t rq);
    nbc_pkg::res_t rs;
    int            first_free;
    int            oldest;
    int            tgt;
    rs         = '0;
    first_free = -1;
    oldest     = -1;
    if (rq.kind == nbc_pkg::KindLookup) begin
      for (int i = 0; i < nbc_pkg::Entries; i++) begin
        if (shadow_valid[i] && shadow_ip[i] == rq.ip) begin
          rs.slot = nbc_pkg::SlotW'(i);
          // The age is taken modulo the 48-bit wrap of the uptime counter.
          if (nbc_pkg::TimeW'(rq.now_ms - shadow_stamp[i]) > lifetime_ms) begin
            shadow_valid[i] = 1'b0;
            n_expired++;
          end else begin
            rs.found   = 1'b1;
            rs.mac_out = shadow_mac[i];
            n_hit++;
          end
          return rs;
        end
      end
      n_miss++;
      return rs;
    end
    for (int i = 0; i < nbc_pkg::Entries; i++) begin
      if (shadow_valid[i] && shadow_ip[i] == rq.ip) begin
        shadow_mac[i]   = rq.new_mac;
        shadow_stamp[i] = rq.now_ms;
        rs.found        = 1'b1;
        rs.slot         = nbc_pkg::SlotW'(i);
        n_refresh++;
        return rs;
      end
      if (!shadow_valid[i]) begin
        if (first_free < 0) first_free = i;
      end else if (oldest < 0 || shadow_stamp[i] < shadow_stamp[oldest]) begin
        oldest = i;
      end
    end
    if (first_free >= 0) begin
      tgt = first_free;
      n_fill++;
    end else begin
      tgt = (oldest >= 0) ? oldest : 0;
      n_evict++;
    end
    shadow_valid[tgt] = 1'b1;
    shadow_ip[tgt]    = rq.ip;
    shadow_mac[tgt]   = rq.new_mac;
    shadow_stamp[tgt] = rq.now_ms;
    rs.slot           = nbc_pkg::SlotW'(tgt);
    return rs;
  endfunction

  // Request driver: a request is taken when start is high and busy is low.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (start && !busy) begin
        awaited_res.push_back(cache_predict(req_i));
        n_taken++;
        if (req_backlog.size() != 0 && req_backlog[0].gap == 0) begin
          req_i <= req_backlog[0].rq;
          void'(req_backlog.pop_front());
        end else begin
          start <= 1'b0;
        end
      end else if (!start && req_backlog.size() != 0) begin
        if (req_backlog[0].gap != 0) begin
          req_backlog[0].gap = req_backlog[0].gap - 5'd1;
        end else begin
          req_i <= req_backlog[0].rq;
          start <= 1'b1;
          void'(req_backlog.pop_front());
        end
      end
    end
  end

  // Result monitor: every strobe must match the oldest outstanding prediction.
  always @(posedge clk_i) begin
    nbc_pkg::res_t want;
    if (rst_ni && res_strobe_o) begin
      if (awaited_res.size() == 0) begin
        fault_count++;
        if (fault_count <= ReportLimit)
          $display("%0t: result with nothing outstanding: found=%0b mac=%h slot=%0d",
                   $time, res_o.found, res_o.mac_out, res_o.slot);
      end else begin
        want = awaited_res.pop_front();
        if (res_o.found !== want.found || res_o.mac_out !== want.mac_out ||
            res_o.slot !== want.slot) begin
          fault_count++;
          if (fault_count <= ReportLimit)
            $display("%0t: mismatch: expected found=%0b mac=%h slot=%0d, %s",
                     $time, want.found, want.mac_out, want.slot,
                     $sformatf("got found=%0b mac=%h slot=%0d",
                               res_o.found, res_o.mac_out, res_o.slot));
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= CycleLimit) begin
      $display("%0t: timeout with %0d results outstanding", $time, awaited_res.size());
      $display("tb_neighbor_cache_with_ttl: errors");
      $finish;
    end
  end

  task automatic queue_op(input logic kind, input logic [nbc_pkg::IpW-1:0] ip,
                          input logic [nbc_pkg::MacW-1:0] mac,
                          input logic [nbc_pkg::TimeW-1:0] now);
    queued_req_t item;
    item.rq.kind    = kind;
    item.rq.ip      = ip;
    item.rq.new_mac = mac;
    item.rq.now_ms  = now;
    // Back-to-back stretches alternate with randomly spaced requests.
    item.gap = (n_queued % 50 < 20) ? 5'd0 : 5'($urandom_range(0, 18));
    req_backlog.push_back(item);
    n_queued++;
  endtask

  task automatic drain();
    while (n_taken < n_queued || awaited_res.size() != 0) @(posedge clk_i);
  endtask

  task automatic write_lifetime(input logic [nbc_pkg::TimeW-1:0] value);
    @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= value;
    do @(posedge clk_i); while (!cfg_ready_o);
    lifetime_ms = value;
    cfg_valid_i <= 1'b0;
  endtask

  // Random traffic over a small address pool, so that the table fills and
  // entries are both evicted and aged out. The clock advance is scaled to
  // the lifetime so that looked-up ages fall on both sides of it.
  task automatic random_phase(input int n, input int unsigned scale);
    logic                    kind;
    logic [nbc_pkg::IpW-1:0] ip;
    for (int i = 0; i < PoolSize; i++) ip_pool[i] = $urandom;
    clock_ms = nbc_pkg::TimeW'({$urandom, $urandom});
    for (int k = 0; k < n; k++) begin
      kind = ($urandom_range(0, 99) < 45) ? nbc_pkg::KindInsert : nbc_pkg::KindLookup;
      ip   = ($urandom_range(0, 99) < 85) ? ip_pool[$urandom_range(0, PoolSize - 1)]
                                          : nbc_pkg::IpW'($urandom);
      if ($urandom_range(0, 24) == 0)
        clock_ms = nbc_pkg::TimeW'({$urandom, $urandom});
      else if ($urandom_range(0, 9) > 2)
        clock_ms = clock_ms + nbc_pkg::TimeW'($urandom_range(0, scale));
      queue_op(kind, ip, nbc_pkg::MacW'({$urandom, $urandom}), clock_ms);
    end
    drain();
  endtask

  initial begin
    int unsigned mid_life;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Reset lifetime: misses, hits at exactly the lifetime, expiry, wrap and refresh.
    queue_op(nbc_pkg::KindLookup, 32'h0000_0000, '1, '1);
    queue_op(nbc_pkg::KindInsert, 32'hFFFF_FFFF, '1, 48'd0);
    queue_op(nbc_pkg::KindInsert, 32'h0000_0000, '0, '1);
    queue_op(nbc_pkg::KindLookup, 32'hFFFF_FFFF, '0, 48'd300000);
    queue_op(nbc_pkg::KindLookup, 32'h0000_0000, '1, 48'd299999);
    queue_op(nbc_pkg::KindLookup, 32'hFFFF_FFFF, '0, 48'd300001);
    queue_op(nbc_pkg::KindLookup, 32'hFFFF_FFFF, '0, 48'd300001);
    queue_op(nbc_pkg::KindInsert, 32'h0000_0000, 48'hA5A5_A5A5_A5A5, 48'd100);
    queue_op(nbc_pkg::KindInsert, 32'h1234_5678, 48'h5A5A_5A5A_5A5A, 48'd50);
    queue_op(nbc_pkg::KindLookup, 32'h0000_0000, '1, 48'd100);
    queue_op(nbc_pkg::KindLookup, 32'h1234_5678, '0, 48'd49);
    queue_op(nbc_pkg::KindLookup, 32'h8000_0001, '1, 48'h8000_0000_0000);
    drain();

    // With a zero lifetime only an age of zero survives.
    write_lifetime('0);
    queue_op(nbc_pkg::KindInsert, 32'h0000_0001, 48'h0000_0000_0001, 48'd7);
    queue_op(nbc_pkg::KindLookup, 32'h0000_0001, '0, 48'd7);
    queue_op(nbc_pkg::KindLookup, 32'h0000_0001, '0, 48'd8);
    drain();
    random_phase(110, 1);

    // With the largest lifetime nothing ever expires, even across the wrap.
    write_lifetime('1);
    queue_op(nbc_pkg::KindInsert, 32'h0000_0002, 48'h0000_0000_0002, 48'd1);
    queue_op(nbc_pkg::KindLookup, 32'h0000_0002, '0, 48'd0);
    drain();
    random_phase(110, 1000000);

    write_lifetime(nbc_pkg::LifetimeReset);
    random_phase(130, 25000);

    write_lifetime(48'd2000);
    random_phase(130, 170);

    mid_life = $urandom_range(1000, 60000);
    write_lifetime(nbc_pkg::TimeW'(mid_life));
    random_phase(120, mid_life / 12);

    repeat (40) @(posedge clk_i);
    if (awaited_res.size() != 0) begin
      fault_count += awaited_res.size();
      $display("%0d results never arrived", awaited_res.size());
    end
    $display("Ran %0d requests: lookups gave %0d hits, %0d misses and %0d expiries.",
             n_taken, n_hit, n_miss, n_expired);
    $display("Inserts gave %0d refreshes, %0d writes to free entries and %0d evictions.",
             n_refresh, n_fill, n_evict);
    if (fault_count == 0) begin
      $display("tb_neighbor_cache_with_ttl: clean");
    end else begin
      $display("tb_neighbor_cache_with_ttl: errors");
    end
    $finish;
  end

endmodule
